// ----- sv/ier_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ier_pkg;

    // Frame buffer geometry
    localparam int MAX_FRAME = 2048;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int CNT_W     = ADDR_W + 1;

    // Frame layout
    localparam int ICMP_AT   = 34;
    localparam int MIN_REPLY = 60;

    // ICMP types
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IP_SHORT  = 3'd1;
    localparam logic [2:0] ST_NOT_ECHO  = 3'd2;
    localparam logic [2:0] ST_BAD_SUM   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;
    localparam logic [2:0] ST_NO_REPLY  = 3'd6;

    // Result kinds
    localparam logic RK_VERDICT = 1'b0;
    localparam logic RK_BYTE    = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic read;
        logic judge;
        logic capture;
    } ier_cmd_t;

    // End-around-carry fold of a 17-bit partial sum
    function automatic logic [15:0] ier_fold(input logic [16:0] s);
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

// ----- sv/ier_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ier_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output op, output data_byte, output frame_last,
                    input ready);
    modport sink   (input valid, input op, input data_byte, input frame_last,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/ier_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ier_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [2:0]  status;
    logic [11:0] reply_length;
    logic [7:0]  reply_byte;
    logic        reply_last;

    modport source (output valid, output result_kind, output status,
                    output reply_length, output reply_byte, output reply_last,
                    input ready);
    modport sink   (input valid, input result_kind, input status,
                    input reply_length, input reply_byte, input reply_last,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/ier_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ier_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_ttl;

    modport source (output valid, output reply_ttl, input ready);
    modport sink   (input valid, input reply_ttl, output ready);
endinterface

`default_nettype wire

// ----- sv/icmp_echo_responder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// ICMP echo responder for IPv4 frames with a 20-byte IP header. Load words
// (op 0) write one frame byte each and are taken one per cycle while no
// result is pending. A word that returns a result (the load word with
// frame_last, or a read word, op 1) is taken in the idle state, and for a
// read the frame buffer RAM is read at that edge. The judge state then
// judges the frame, or the read-wait state registers the read byte into the
// result. The output state presents the result until it is taken, and the
// next word is taken once the controller is back in the idle state. A
// result must be taken before the next word is accepted.
// reply_ttl is written on the cfg channel, which is always ready, and is
// sampled when a frame is judged.
module icmp_echo_responder (
    input  logic       clk,
    input  logic       rst_n,
    ier_req_if.sink    req,
    ier_rsp_if.source  rsp,
    ier_cfg_if.sink    cfg
);

    ier_pkg::ier_cmd_t cmd;

    assign cfg.ready = 1'b1;

    ier_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_last  (req.frame_last),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    ier_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .data_byte    (req.data_byte),
        .cfg_we       (cfg.valid),
        .cfg_ttl      (cfg.reply_ttl),
        .result_kind  (rsp.result_kind),
        .status       (rsp.status),
        .reply_length (rsp.reply_length),
        .reply_byte   (rsp.reply_byte),
        .reply_last   (rsp.reply_last)
    );

endmodule

`default_nettype wire

// ----- sv/ier_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ier_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/ier_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ier_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ier_pkg::ier_cmd_t   cmd,
    input  logic [7:0]          data_byte,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_ttl,
    output logic                result_kind,
    output logic [2:0]          status,
    output logic [11:0]         reply_length,
    output logic [7:0]          reply_byte,
    output logic                reply_last
);

    localparam int CW = ier_pkg::CNT_W;
    localparam int AW = ier_pkg::ADDR_W;

    // Frame accumulation state
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          too_long_reg, too_long_next;
    logic [15:0]   ipl_reg, ipl_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    code_reg, code_next;
    logic [15:0]   sum_reg, sum_next;     // full ICMP sum for the check
    logic [15:0]   csum_reg, csum_next;   // ICMP sum with type and checksum zeroed
    logic [15:0]   hsum_reg, hsum_next;   // IP header sum without TTL and checksum
    // Reply state
    logic [CW-1:0] rp_reg, rp_next;
    logic          ready_reg, ready_next;
    logic [CW-1:0] body_reg, body_next;
    logic [CW-1:0] rlen_reg, rlen_next;
    logic [7:0]    ttl_cap_reg, ttl_cap_next;
    logic [15:0]   icmp_ck_reg, icmp_ck_next;
    logic [15:0]   ip_ck_reg, ip_ck_next;
    logic [7:0]    ttl_reg, ttl_next;
    // Pending read
    logic [CW-1:0] rd_pos_reg, rd_pos_next;
    logic          rd_ok_reg, rd_ok_next;
    logic          rd_body_reg, rd_body_next;
    logic          rd_last_reg, rd_last_next;
    // Result word
    logic          kind_reg, kind_next;
    logic [2:0]    st_reg, st_next;
    logic [11:0]   len_reg, len_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_q;

    logic [16:0]   ipl_end;
    logic [15:0]   word;
    logic          in_icmp;
    logic          stored;
    logic [2:0]    verdict;
    logic [CW-1:0] rd_map;
    logic [7:0]    rd_byte;

    assign ipl_end = {1'b0, ipl_reg} + 17'd14;
    assign stored  = cnt_reg < CW'(ier_pkg::MAX_FRAME);
    assign word    = cnt_reg[0] ? {8'd0, data_byte} : {data_byte, 8'd0};
    assign in_icmp = (cnt_reg >= CW'(ier_pkg::ICMP_AT)) && ({{(17-CW){1'b0}}, cnt_reg} < ipl_end);
    assign ram_we  = cmd.load && stored;

    // Verdict, in order of precedence
    always_comb
    begin
        if (too_long_reg)
            verdict = ier_pkg::ST_TOO_LONG;
        else if (ipl_reg < 16'd28)
            verdict = ier_pkg::ST_IP_SHORT;
        else if (type_reg != ier_pkg::ICMP_ECHO_REQUEST || code_reg != 8'd0)
            verdict = ier_pkg::ST_NOT_ECHO;
        else if (sum_reg != 16'hFFFF)
            verdict = ier_pkg::ST_BAD_SUM;
        else if ({{(17-CW){1'b0}}, cnt_reg} < ipl_end)
            verdict = ier_pkg::ST_TRUNCATED;
        else
            verdict = ier_pkg::ST_OK;
    end

    // Read address: MACs and IPs swapped
    always_comb
    begin
        if (rp_reg < CW'(6))
            rd_map = rp_reg + CW'(6);
        else if (rp_reg < CW'(12))
            rd_map = rp_reg - CW'(6);
        else if (rp_reg >= CW'(26) && rp_reg < CW'(30))
            rd_map = rp_reg + CW'(4);
        else if (rp_reg >= CW'(30) && rp_reg < CW'(34))
            rd_map = rp_reg - CW'(4);
        else
            rd_map = rp_reg;
    end
    assign ram_raddr = rd_map[AW-1:0];

    // Rewritten header fields override the stored bytes
    always_comb
    begin
        if (!rd_body_reg)
            rd_byte = 8'd0;
        else if (rd_pos_reg == CW'(22))
            rd_byte = ttl_cap_reg;
        else if (rd_pos_reg == CW'(24))
            rd_byte = ip_ck_reg[15:8];
        else if (rd_pos_reg == CW'(25))
            rd_byte = ip_ck_reg[7:0];
        else if (rd_pos_reg == CW'(ier_pkg::ICMP_AT))
            rd_byte = ier_pkg::ICMP_ECHO_REPLY;
        else if (rd_pos_reg == CW'(ier_pkg::ICMP_AT + 2))
            rd_byte = icmp_ck_reg[15:8];
        else if (rd_pos_reg == CW'(ier_pkg::ICMP_AT + 3))
            rd_byte = icmp_ck_reg[7:0];
        else
            rd_byte = ram_q;
    end

    // Next-state logic
    always_comb
    begin
        cnt_next     = cnt_reg;
        too_long_next = too_long_reg;
        ipl_next     = ipl_reg;
        type_next    = type_reg;
        code_next    = code_reg;
        sum_next     = sum_reg;
        csum_next    = csum_reg;
        hsum_next    = hsum_reg;
        rp_next      = rp_reg;
        ready_next   = ready_reg;
        body_next    = body_reg;
        rlen_next    = rlen_reg;
        ttl_cap_next = ttl_cap_reg;
        icmp_ck_next = icmp_ck_reg;
        ip_ck_next   = ip_ck_reg;
        ttl_next     = cfg_we ? cfg_ttl : ttl_reg;
        rd_pos_next  = rd_pos_reg;
        rd_ok_next   = rd_ok_reg;
        rd_body_next = rd_body_reg;
        rd_last_next = rd_last_reg;
        kind_next    = kind_reg;
        st_next      = st_reg;
        len_next     = len_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;

        if (cmd.load)
        begin
            // first word of a frame discards any unread reply
            if (cnt_reg == '0 && !too_long_reg)
            begin
                ready_next = 1'b0;
                rp_next    = '0;
            end
            if (stored)
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(16)) ipl_next[15:8] = data_byte;
                if (cnt_reg == CW'(17)) ipl_next[7:0]  = data_byte;
                if (cnt_reg == CW'(ier_pkg::ICMP_AT))     type_next = data_byte;
                if (cnt_reg == CW'(ier_pkg::ICMP_AT + 1)) code_next = data_byte;
                if (in_icmp)
                begin
                    sum_next = ier_pkg::ier_fold({1'b0, sum_reg} + {1'b0, word});
                    if (cnt_reg != CW'(ier_pkg::ICMP_AT) &&
                        cnt_reg != CW'(ier_pkg::ICMP_AT + 2) &&
                        cnt_reg != CW'(ier_pkg::ICMP_AT + 3))
                        csum_next = ier_pkg::ier_fold({1'b0, csum_reg} + {1'b0, word});
                end
                if (cnt_reg >= CW'(14) && cnt_reg < CW'(ier_pkg::ICMP_AT) &&
                    cnt_reg != CW'(22) && cnt_reg != CW'(24) && cnt_reg != CW'(25))
                    hsum_next = ier_pkg::ier_fold({1'b0, hsum_reg} + {1'b0, word});
            end
            else
            begin
                too_long_next = 1'b1;
            end
        end

        if (cmd.judge)
        begin
            body_next    = ipl_end[CW-1:0];
            rlen_next    = (ipl_end < 17'(ier_pkg::MIN_REPLY)) ?
                           CW'(ier_pkg::MIN_REPLY) : ipl_end[CW-1:0];
            ttl_cap_next = ttl_reg;
            icmp_ck_next = ~csum_reg;
            ip_ck_next   = ~ier_pkg::ier_fold({1'b0, hsum_reg} + {1'b0, ttl_reg, 8'd0});
            ready_next   = (verdict == ier_pkg::ST_OK);
            rp_next      = '0;
            kind_next    = ier_pkg::RK_VERDICT;
            st_next      = verdict;
            len_next     = (verdict == ier_pkg::ST_OK) ? 12'(rlen_next) : 12'd0;
            byte_next    = 8'd0;
            last_next    = 1'b0;
            // fresh frame
            cnt_next      = '0;
            too_long_next = 1'b0;
            ipl_next      = '0;
            type_next     = '0;
            code_next     = '0;
            sum_next      = '0;
            csum_next     = '0;
            hsum_next     = '0;
        end

        if (cmd.read)
        begin
            rd_pos_next  = rp_reg;
            rd_body_next = rp_reg < body_reg;
            if (!ready_reg || rp_reg >= rlen_reg)
            begin
                ready_next = 1'b0;
                rd_ok_next = 1'b0;
            end
            else
            begin
                rd_ok_next   = 1'b1;
                rp_next      = rp_reg + CW'(1);
                rd_last_next = (rp_reg + CW'(1)) >= rlen_reg;
                if (rd_last_next)
                    ready_next = 1'b0;
            end
        end

        if (cmd.capture)
        begin
            kind_next = ier_pkg::RK_BYTE;
            st_next   = rd_ok_reg ? ier_pkg::ST_OK : ier_pkg::ST_NO_REPLY;
            len_next  = rd_ok_reg ? 12'(rlen_reg) : 12'd0;
            byte_next = rd_ok_reg ? rd_byte : 8'd0;
            last_next = rd_ok_reg && rd_last_reg;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            too_long_reg <= 1'b0;
            ipl_reg      <= '0;
            type_reg     <= '0;
            code_reg     <= '0;
            sum_reg      <= '0;
            csum_reg     <= '0;
            hsum_reg     <= '0;
            rp_reg       <= '0;
            ready_reg    <= 1'b0;
            body_reg     <= '0;
            rlen_reg     <= '0;
            ttl_cap_reg  <= '0;
            icmp_ck_reg  <= '0;
            ip_ck_reg    <= '0;
            ttl_reg      <= 8'd64;
            rd_pos_reg   <= '0;
            rd_ok_reg    <= 1'b0;
            rd_body_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
            kind_reg     <= 1'b0;
            st_reg       <= '0;
            len_reg      <= '0;
            byte_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            too_long_reg <= too_long_next;
            ipl_reg      <= ipl_next;
            type_reg     <= type_next;
            code_reg     <= code_next;
            sum_reg      <= sum_next;
            csum_reg     <= csum_next;
            hsum_reg     <= hsum_next;
            rp_reg       <= rp_next;
            ready_reg    <= ready_next;
            body_reg     <= body_next;
            rlen_reg     <= rlen_next;
            ttl_cap_reg  <= ttl_cap_next;
            icmp_ck_reg  <= icmp_ck_next;
            ip_ck_reg    <= ip_ck_next;
            ttl_reg      <= ttl_next;
            rd_pos_reg   <= rd_pos_next;
            rd_ok_reg    <= rd_ok_next;
            rd_body_reg  <= rd_body_next;
            rd_last_reg  <= rd_last_next;
            kind_reg     <= kind_next;
            st_reg       <= st_next;
            len_reg      <= len_next;
            byte_reg     <= byte_next;
            last_reg     <= last_next;
        end
    end

    // Frame buffer
    ier_ram #(.WIDTH(8), .DEPTH(ier_pkg::MAX_FRAME)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (data_byte),
        .re    (cmd.read),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign result_kind  = kind_reg;
    assign status       = st_reg;
    assign reply_length = len_reg;
    assign reply_byte   = byte_reg;
    assign reply_last   = last_reg;

    // Read position never runs past the reply
    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> rp_reg < rlen_reg)
        else $error("read position past reply end");

    // A judged good frame leaves a reply of at least minimum length
    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.judge && verdict == ier_pkg::ST_OK |=> ready_reg &&
            rlen_reg >= CW'(ier_pkg::MIN_REPLY))
        else $error("accepted frame without reply");

    // The last reply byte drops the reply
    a_last_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read && ready_reg && (rp_reg + CW'(1)) >= rlen_reg |=> !ready_reg)
        else $error("reply kept after last byte");

endmodule

`default_nettype wire

// ----- sv/ier_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ier_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_op,
    input  logic              req_last,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ier_pkg::ier_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_JUDGE,
        S_RD_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;

    // Commands to the datapath
    always_comb
    begin
        cmd.load    = accept && !req_op;
        cmd.read    = accept && req_op;
        cmd.judge   = (state_reg == S_JUDGE);
        cmd.capture = (state_reg == S_RD_WAIT);
    end

    // State and result-valid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && req_op)
                        state_reg <= S_RD_WAIT;
                    else if (accept && req_last)
                        state_reg <= S_JUDGE;
                end
                S_JUDGE, S_RD_WAIT:
                begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (rsp_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // No new word taken while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("input taken with result pending");

    // Verdict and read byte both reach the output next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.judge || cmd.capture |=> rsp_valid)
        else $error("result not presented");

    // Plain load words leave the controller ready for the next word
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && !req_last |=> req_ready)
        else $error("load stalled");

endmodule

`default_nettype wire
